// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SIM_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define SIM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle implication failed");

`endif

// ----- hdl/sim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert and merge package
// Word types, command codes and status codes shared by the block and its
// checker.
// ----------------------------------------------------------------------------
package sim_pkg;

   localparam int DEFAULT_DEPTH       = 32;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam logic [1:0] CMD_INSERT_A = 2'd0;
   localparam logic [1:0] CMD_INSERT_B = 2'd1;
   localparam logic [1:0] CMD_MERGE    = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_MERGED   = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
   } sim_req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic [1:0]         status;
      logic               last;
   } sim_rsp_type;

endpackage

// ----- hdl/sim_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted store memory
// One write port and one read port; the read word is registered, so it
// appears in the cycle after its address.
// ----------------------------------------------------------------------------
module sim_store #(
   parameter int DEPTH       = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [VALUE_WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [VALUE_WIDTH-1:0]         rd_data
);

   logic [VALUE_WIDTH-1:0] mem_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sorted_insert_and_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert and merge
// Two bounded sorted stores with ordered insertion and a merged read-out.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. An insert answers with
// one result: in the cycle after the word is taken when the store is full or
// empty, otherwise once the shift loop has moved each entry larger than the
// new value up one place, one per cycle through the store's one read port
// and one write port.
// A merge reads both store heads in parallel and emits one result per cycle,
// 1 to 2 * DEPTH results back to back, then empties both stores. The last
// result of each word is shown while busy is already low. Results are
// strobed for one cycle and cannot be held off by the receiver.
module sorted_insert_and_merge #(
   parameter int DEPTH       = sim_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = sim_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sim_pkg::sim_req_type req_data,
   output logic                 rsp_strobe,
   output sim_pkg::sim_rsp_type rsp_data
);
   import sim_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int VW = VALUE_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_INSERT_HEAD,
      S_MERGE
   } state_type;

   state_type              state_ff, state_in;
   logic                   sel_b_ff, sel_b_in;
   logic [VW-1:0]          key_ff, key_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          ia_ff, ia_in;
   logic [CW-1:0]          ib_ff, ib_in;
   logic [CW-1:0]          count_a_ff, count_a_in;
   logic [CW-1:0]          count_b_ff, count_b_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sim_rsp_type            rsp_ff, rsp_in;

   logic                   accept;
   logic [VW+31:0]         value_ext;
   logic [VW-1:0]          key_new;
   logic [CW-1:0]          n_req;
   logic [CW-1:0]          n_less;
   logic [CW-1:0]          idx_less;
   logic [CW-1:0]          idx_less2;
   logic [VW-1:0]          rd_a, rd_b, ins_data;
   logic                   we_a, we_b;
   logic [AW-1:0]          waddr;
   logic [VW-1:0]          wdata;
   logic [AW-1:0]          raddr_a, raddr_b;
   logic                   a_ok, b_ok;
   logic [VW-1:0]          picked;
   logic [VW+31:0]         picked_ext;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   // The input word is taken as its low VALUE_WIDTH bits, zero-extended.
   assign value_ext = {{VW{1'b0}}, req_data.value};
   assign key_new   = value_ext[VW-1:0];
   assign n_req     = req_data.cmd[0] ? count_b_ff : count_a_ff;
   assign n_less    = n_req - CW'(1);
   assign idx_less  = idx_ff - CW'(1);
   assign idx_less2 = idx_ff - CW'(2);
   assign ins_data  = sel_b_ff ? rd_b : rd_a;
   assign a_ok      = (ia_ff < count_a_ff);
   assign b_ok      = (ib_ff < count_b_ff);

   always_comb begin
      state_in     = state_ff;
      sel_b_in     = sel_b_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      we_a         = 1'b0;
      we_b         = 1'b0;
      waddr        = '0;
      wdata        = key_ff;
      raddr_a      = '0;
      raddr_b      = '0;
      picked       = rd_a;
      picked_ext   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_INSERT_A, CMD_INSERT_B: begin
                     sel_b_in = req_data.cmd[0];
                     key_in   = key_new;
                     if (n_req == CW'(DEPTH)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                        rsp_in.last   = 1'b1;
                     end else begin
                        if (req_data.cmd[0]) begin
                           count_b_in = count_b_ff + CW'(1);
                        end else begin
                           count_a_in = count_a_ff + CW'(1);
                        end
                        if (n_req == '0) begin
                           we_a          = !req_data.cmd[0];
                           we_b          = req_data.cmd[0];
                           wdata         = key_new;
                           rsp_valid_in  = 1'b1;
                           rsp_in.status = STATUS_INSERTED;
                           rsp_in.last   = 1'b1;
                        end else begin
                           raddr_a  = n_less[AW-1:0];
                           raddr_b  = n_less[AW-1:0];
                           idx_in   = n_req;
                           state_in = S_INSERT;
                        end
                     end
                  end
                  CMD_MERGE: begin
                     if (count_a_ff == '0 && count_b_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                        rsp_in.last   = 1'b1;
                     end else begin
                        ia_in    = '0;
                        ib_in    = '0;
                        state_in = S_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_INSERT: begin
            // The entry below the write slot is on the read port this cycle.
            we_a  = !sel_b_ff;
            we_b  = sel_b_ff;
            waddr = idx_ff[AW-1:0];
            if ($signed(ins_data) > $signed(key_ff)) begin
               wdata  = ins_data;
               idx_in = idx_less;
               if (idx_ff == CW'(1)) begin
                  state_in = S_INSERT_HEAD;
               end else begin
                  raddr_a = idx_less2[AW-1:0];
                  raddr_b = idx_less2[AW-1:0];
               end
            end else begin
               wdata         = key_ff;
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_INSERTED;
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_INSERT_HEAD: begin
            we_a          = !sel_b_ff;
            we_b          = sel_b_ff;
            waddr         = '0;
            wdata         = key_ff;
            rsp_valid_in  = 1'b1;
            rsp_in.status = STATUS_INSERTED;
            rsp_in.last   = 1'b1;
            state_in      = S_IDLE;
         end

         S_MERGE: begin
            if (a_ok && b_ok) begin
               if ($signed(rd_a) < $signed(rd_b)) begin
                  picked = rd_a;
                  ia_in  = ia_ff + CW'(1);
               end else if ($signed(rd_b) < $signed(rd_a)) begin
                  picked = rd_b;
                  ib_in  = ib_ff + CW'(1);
               end else begin
                  // Equal heads are emitted once and both stores advance.
                  picked = rd_a;
                  ia_in  = ia_ff + CW'(1);
                  ib_in  = ib_ff + CW'(1);
               end
            end else if (a_ok) begin
               picked = rd_a;
               ia_in  = ia_ff + CW'(1);
            end else begin
               picked = rd_b;
               ib_in  = ib_ff + CW'(1);
            end
            // Heads for the next cycle; a pointer past the end reads a
            // harmless wrapped address.
            raddr_a          = ia_in[AW-1:0];
            raddr_b          = ib_in[AW-1:0];
            picked_ext       = {32'b0, picked};
            rsp_valid_in     = 1'b1;
            rsp_in.out_value = picked_ext[31:0];
            rsp_in.status    = STATUS_MERGED;
            rsp_in.last      = !((ia_in < count_a_ff) || (ib_in < count_b_ff));
            if (rsp_in.last) begin
               count_a_in = '0;
               count_b_in = '0;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_b_ff <= sel_b_in;
      key_ff   <= key_in;
      idx_ff   <= idx_in;
      ia_ff    <= ia_in;
      ib_ff    <= ib_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   sim_store #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr_a),
      .rd_data (rd_a)
   );

   sim_store #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr_b),
      .rd_data (rd_b)
   );

endmodule

// ----- hdl/sim_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert and merge checker
// Watches the top-level ports for result framing and command handling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sim_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input sim_pkg::sim_req_type req_data,
   input logic                 rsp_strobe,
   input sim_pkg::sim_rsp_type rsp_data
);
   import sim_pkg::*;

   logic single_rsp;
   logic merged_rsp;
   logic run_open;
   logic unused_taken;

   assign single_rsp   = rsp_strobe && rsp_data.status != STATUS_MERGED;
   assign merged_rsp   = rsp_strobe && rsp_data.status == STATUS_MERGED;
   assign run_open     = rsp_strobe && !rsp_data.last;
   assign unused_taken = start && !busy && req_data.cmd == CMD_UNUSED;

   // Only merged items come in runs; every other result stands alone.
   `SIM_ASSERT_IMPLY(a_single_is_last, clock, reset, single_rsp, rsp_data.last)

   `SIM_ASSERT_IMPLY(a_status_value_zero, clock, reset, single_rsp, rsp_data.out_value == '0)

   // A merge run has no gaps until its last word.
   `SIM_ASSERT_NEXT(a_merge_run_unbroken, clock, reset, run_open, merged_rsp)

   `SIM_ASSERT_NEXT(a_unused_silent, clock, reset, unused_taken, !rsp_strobe && !busy)

endmodule

bind sorted_insert_and_merge sim_checker u_sim_checker (.*);
